// ===== hw/rtl/mandelbrot_escape_time_top_assert.svh =====
// assertion helpers for the mandelbrot escape time block
`ifndef MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define MET_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("%m: check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define MET_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, constants and helpers of the Mandelbrot escape time block.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int MAX_SIDE   = 4096;
    localparam int FRAC_BITS  = 28;

    localparam int COORD_W    = 12;
    localparam int SIDE_W     = 13;
    localparam int COUNT_W    = 16;
    localparam int FIX_W      = 32;
    localparam int DIFF_W     = FIX_W + 1;
    localparam int STEP_W     = DIFF_W + 1;
    localparam int SUM_W      = 48;
    localparam int PROD_W     = 2 * FIX_W;
    localparam int DIV_STEPS  = DIFF_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int FIFO_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX           = 3'd6;

    localparam logic [SIDE_W-1:0]        RST_IMAGE_WIDTH     = 13'd640;
    localparam logic [SIDE_W-1:0]        RST_IMAGE_HEIGHT    = 13'd480;
    localparam logic [COUNT_W-1:0]       RST_ITERATION_LIMIT = 16'd256;
    localparam logic signed [FIX_W-1:0]  RST_X_MIN           = -32'sd536870912;
    localparam logic signed [FIX_W-1:0]  RST_X_MAX           = 32'sd268435456;
    localparam logic signed [FIX_W-1:0]  RST_Y_MIN           = -32'sd268435456;
    localparam logic signed [FIX_W-1:0]  RST_Y_MAX           = 32'sd268435456;

    typedef struct packed {
        logic signed [FIX_W-1:0] c_re;
        logic signed [FIX_W-1:0] c_im;
        logic [COORD_W-1:0]      column;
        logic [COORD_W-1:0]      row;
    } t_point;

    // clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic hi_same;
        hi_same = (v[SUM_W-1:FIX_W-1] == '0) || (v[SUM_W-1:FIX_W-1] == '1);
        if (hi_same) begin
            return v[FIX_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(FIX_W-1){1'b0}}};
        end else begin
            return {1'b0, {(FIX_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hw/rtl/met_step_div.sv =====
// ----------------------------------------------------------------------------
// met_step_div
// Works out the x and y pixel steps, (hi - lo) / side truncated toward zero,
// with a restoring divider that retires one quotient bit per cycle per axis.
// ----------------------------------------------------------------------------
module met_step_div import met_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_recalc,
    input  logic [SIDE_W-1:0]        i_image_width,
    input  logic [SIDE_W-1:0]        i_image_height,
    input  logic signed [FIX_W-1:0]  i_x_min,
    input  logic signed [FIX_W-1:0]  i_x_max,
    input  logic signed [FIX_W-1:0]  i_y_min,
    input  logic signed [FIX_W-1:0]  i_y_max,
    output logic                     o_busy,
    output logic signed [STEP_W-1:0] o_step_x,
    output logic signed [STEP_W-1:0] o_step_y
);

    logic                     r_pending;
    logic                     r_run;
    logic [CNT_W-1:0]         r_cnt;
    logic [DIFF_W-1:0]        r_quo [2];
    logic [SIDE_W:0]          r_rem [2];
    logic [SIDE_W-1:0]        r_div [2];
    logic                     r_neg [2];
    logic signed [STEP_W-1:0] r_step [2];

    logic signed [FIX_W-1:0]  lo [2];
    logic signed [FIX_W-1:0]  hi [2];
    logic [SIDE_W-1:0]        side [2];
    logic signed [DIFF_W-1:0] diff [2];
    logic [DIFF_W-1:0]        mag [2];
    logic [SIDE_W-1:0]        div_clamp [2];
    logic [SIDE_W:0]          rem_sh [2];
    logic                     ge [2];
    logic [SIDE_W:0]          n_rem [2];
    logic [DIFF_W-1:0]        n_quo [2];
    logic                     last;

    assign last = r_run && (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        lo[0]   = i_x_min;
        hi[0]   = i_x_max;
        side[0] = i_image_width;
        lo[1]   = i_y_min;
        hi[1]   = i_y_max;
        side[1] = i_image_height;
        for (int l = 0; l < 2; l++) begin
            diff[l] = {hi[l][FIX_W-1], hi[l]} - {lo[l][FIX_W-1], lo[l]};
            mag[l]  = diff[l][DIFF_W-1] ? DIFF_W'(-diff[l]) : DIFF_W'(diff[l]);
            if (side[l] == '0) begin
                div_clamp[l] = SIDE_W'(1);
            end else if (side[l] > SIDE_W'(MAX_SIDE)) begin
                div_clamp[l] = SIDE_W'(MAX_SIDE);
            end else begin
                div_clamp[l] = side[l];
            end
            rem_sh[l] = {r_rem[l][SIDE_W-1:0], r_quo[l][DIFF_W-1]};
            ge[l]     = rem_sh[l] >= {1'b0, r_div[l]};
            n_rem[l]  = ge[l] ? (rem_sh[l] - {1'b0, r_div[l]}) : rem_sh[l];
            n_quo[l]  = {r_quo[l][DIFF_W-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b1;
            r_run     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (r_pending) begin
                r_pending <= i_recalc;
                r_run     <= 1'b1;
                r_cnt     <= '0;
            end else begin
                r_pending <= i_recalc;
                if (last) begin
                    r_run <= 1'b0;
                end
                if (r_run) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (r_pending) begin
                r_quo[l] <= mag[l];
                r_rem[l] <= '0;
                r_div[l] <= div_clamp[l];
                r_neg[l] <= diff[l][DIFF_W-1];
            end else if (r_run) begin
                r_quo[l] <= n_quo[l];
                r_rem[l] <= n_rem[l];
            end
            if (last) begin
                r_step[l] <= r_neg[l] ? -$signed({1'b0, n_quo[l]}) : $signed({1'b0, n_quo[l]});
            end
        end
    end

    assign o_busy   = r_pending || r_run;
    assign o_step_x = r_step[0];
    assign o_step_y = r_step[1];

endmodule

// ===== hw/rtl/met_front.sv =====
// ----------------------------------------------------------------------------
// met_front
// Accepts pixel transactions, scales column and row by the steps and forms
// the saturated point c, then hands it to the queue.
// ----------------------------------------------------------------------------
module met_front import met_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [COORD_W-1:0]       i_column,
    input  logic [COORD_W-1:0]       i_row,
    input  logic                     i_step_busy,
    input  logic signed [STEP_W-1:0] i_step_x,
    input  logic signed [STEP_W-1:0] i_step_y,
    input  logic signed [FIX_W-1:0]  i_x_min,
    input  logic signed [FIX_W-1:0]  i_y_min,
    input  logic                     i_fifo_full,
    output logic                     o_stall,
    output logic                     o_push,
    output t_point                   o_point
);

    localparam int MUL_W = COORD_W + 1 + STEP_W;

    logic                    r_valid;
    logic [COORD_W-1:0]      r_column;
    logic [COORD_W-1:0]      r_row;
    logic signed [MUL_W-1:0] r_px;
    logic signed [MUL_W-1:0] r_py;

    logic                    accept;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    assign o_push  = r_valid && !i_fifo_full;
    assign o_stall = i_step_busy || (r_valid && !o_push);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_column <= i_column;
            r_row    <= i_row;
            r_px     <= $signed({1'b0, i_column}) * i_step_x;
            r_py     <= $signed({1'b0, i_row}) * i_step_y;
        end
    end

    always_comb begin
        sum_x = SUM_W'(i_x_min) + SUM_W'(r_px);
        sum_y = SUM_W'(i_y_min) + SUM_W'(r_py);
        o_point.c_re   = sat32(sum_x);
        o_point.c_im   = sat32(sum_y);
        o_point.column = r_column;
        o_point.row    = r_row;
    end

endmodule

// ===== hw/rtl/met_fifo.sv =====
// ----------------------------------------------------------------------------
// met_fifo
// Short point queue between the front end and the iteration engine.
// ----------------------------------------------------------------------------
module met_fifo import met_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_point i_point,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_point o_point
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    t_point           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [LVL_W-1:0] r_level;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_level == LVL_W'(FIFO_DEPTH));
    assign o_valid = (r_level != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_point = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (do_pop && !do_push) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_point;
        end
    end

endmodule

// ===== hw/rtl/met_iter.sv =====
// ----------------------------------------------------------------------------
// met_iter
// Iteration engine: z = z * z + c from z = 0 until escape or the limit; each
// iteration has a multiply and an update state; registered result transaction.
// ----------------------------------------------------------------------------
module met_iter import met_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_point                  i_point,
    input  logic [COUNT_W-1:0]      i_iteration_limit,
    output logic                    o_pop,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic [COUNT_W-1:0]      o_escape_count,
    output logic [COORD_W-1:0]      o_out_column,
    output logic [COORD_W-1:0]      o_out_row
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam int RE_W = PROD_W - FRAC_BITS;
    localparam int IM_W = PROD_W - FRAC_BITS + 1;

    logic [1:0]                r_state;
    t_point                    r_pt;
    logic signed [FIX_W-1:0]   r_zr;
    logic signed [FIX_W-1:0]   r_zi;
    logic [COUNT_W-1:0]        r_count;
    logic signed [PROD_W-1:0]  r_rr;
    logic signed [PROD_W-1:0]  r_ii;
    logic signed [PROD_W-1:0]  r_ri;
    logic                      r_out_valid;
    logic [COUNT_W-1:0]        r_out_count;
    logic [COORD_W-1:0]        r_out_column;
    logic [COORD_W-1:0]        r_out_row;

    logic [PROD_W-1:0]         mag;
    logic                      escaped;
    logic signed [PROD_W-1:0]  diff;
    logic signed [RE_W-1:0]    re_sh;
    logic signed [IM_W-1:0]    im_sh;
    logic signed [FIX_W-1:0]   n_zr;
    logic signed [FIX_W-1:0]   n_zi;
    logic                      out_free;
    logic                      load_out;

    always_comb begin
        mag     = $unsigned(r_rr) + $unsigned(r_ii);
        // |z|^2 >= 4 in the doubled fraction format
        escaped = |mag[PROD_W-1:2*FRAC_BITS+2];
        diff    = r_rr - r_ii;
        re_sh   = diff[PROD_W-1:FRAC_BITS];
        im_sh   = r_ri[PROD_W-1:FRAC_BITS-1];
        n_zr    = sat32(SUM_W'(re_sh) + SUM_W'(r_pt.c_re));
        n_zi    = sat32(SUM_W'(im_sh) + SUM_W'(r_pt.c_im));
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign load_out = (r_state == S_FIN) && out_free;
    assign o_pop    = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= (r_count >= i_iteration_limit) ? S_FIN : S_UPD;
                end
                S_UPD: begin
                    r_state <= escaped ? S_FIN : S_MUL;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pt    <= i_point;
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end
        if (r_state == S_MUL) begin
            r_rr <= r_zr * r_zr;
            r_ii <= r_zi * r_zi;
            r_ri <= r_zr * r_zi;
        end
        if ((r_state == S_UPD) && !escaped) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + COUNT_W'(1);
        end
        if (load_out) begin
            r_out_count  <= r_count;
            r_out_column <= r_pt.column;
            r_out_row    <= r_pt.row;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_out_count;
    assign o_out_column   = r_out_column;
    assign o_out_row      = r_out_row;

endmodule

// ===== hw/rtl/mandelbrot_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Mandelbrot escape count per pixel, signed Q4.28 fixed point.
// ----------------------------------------------------------------------------
// A pixel transaction (column, row) returns one transaction carrying its
// escape count and the same column and row, in order. Each iteration of the
// engine passes through a multiply state and an update state, since the
// three 32x32 products are registered before the magnitude test and update;
// a result may also wait on the output stall. The reset iteration limit is
// 256. The front end registers the scaled pixel and a two-entry queue lets
// it take the next pixel while the engine is busy. After reset and after each
// register write the pixel steps are recomputed by a bit-serial divider,
// during which the input is stalled.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top import met_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_W-1:0]    i_column,
    input  logic [COORD_W-1:0]    i_row,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COUNT_W-1:0]    o_escape_count,
    output logic [COORD_W-1:0]    o_out_column,
    output logic [COORD_W-1:0]    o_out_row,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "mandelbrot_escape_time_top_assert.svh"

    logic [SIDE_W-1:0]        r_image_width;
    logic [SIDE_W-1:0]        r_image_height;
    logic [COUNT_W-1:0]       r_iteration_limit;
    logic signed [FIX_W-1:0]  r_x_min;
    logic signed [FIX_W-1:0]  r_x_max;
    logic signed [FIX_W-1:0]  r_y_min;
    logic signed [FIX_W-1:0]  r_y_max;

    logic                     cfg_hit;
    logic                     step_busy;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic                     fifo_push;
    logic                     fifo_full;
    logic                     fifo_valid;
    logic                     fifo_pop;
    t_point                   front_point;
    t_point                   queue_point;

    assign cfg_hit = i_cfg_we && (i_cfg_index <= CFG_Y_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= RST_IMAGE_WIDTH;
            r_image_height    <= RST_IMAGE_HEIGHT;
            r_iteration_limit <= RST_ITERATION_LIMIT;
            r_x_min           <= RST_X_MIN;
            r_x_max           <= RST_X_MAX;
            r_y_min           <= RST_Y_MIN;
            r_y_max           <= RST_Y_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[SIDE_W-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[SIDE_W-1:0];
                CFG_ITERATION_LIMIT: r_iteration_limit <= i_cfg_data[COUNT_W-1:0];
                CFG_X_MIN:           r_x_min           <= i_cfg_data[FIX_W-1:0];
                CFG_X_MAX:           r_x_max           <= i_cfg_data[FIX_W-1:0];
                CFG_Y_MIN:           r_y_min           <= i_cfg_data[FIX_W-1:0];
                CFG_Y_MAX:           r_y_max           <= i_cfg_data[FIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    met_step_div u_step_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_recalc       (cfg_hit),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_x_min        (r_x_min),
        .i_x_max        (r_x_max),
        .i_y_min        (r_y_min),
        .i_y_max        (r_y_max),
        .o_busy         (step_busy),
        .o_step_x       (step_x),
        .o_step_y       (step_y)
    );

    met_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_step_busy (step_busy),
        .i_step_x    (step_x),
        .i_step_y    (step_y),
        .i_x_min     (r_x_min),
        .i_y_min     (r_y_min),
        .i_fifo_full (fifo_full),
        .o_stall     (o_in_stall),
        .o_push      (fifo_push),
        .o_point     (front_point)
    );

    met_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_point (front_point),
        .i_pop   (fifo_pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_point (queue_point)
    );

    met_iter u_iter (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (fifo_valid),
        .i_point           (queue_point),
        .i_iteration_limit (r_iteration_limit),
        .o_pop             (fifo_pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_escape_count    (o_escape_count),
        .o_out_column      (o_out_column),
        .o_out_row         (o_out_row)
    );

    `MET_ASSERT_NXT(a_cfg_stalls_input, cfg_hit, o_in_stall && step_busy)
    `MET_ASSERT_IMP(a_no_accept_while_div, i_in_valid && !o_in_stall, !step_busy)
    `MET_ASSERT_IMP(a_count_in_limit, o_out_valid, o_escape_count <= r_iteration_limit)
    `MET_ASSERT_IMP(a_push_has_room, fifo_push, !fifo_full)

endmodule

// ===== tb/mandelbrot_escape_time_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top_test
// Self-checking bench for the Mandelbrot escape time block.
// ----------------------------------------------------------------------------
// Pixels are pushed through the valid/stall input channel while results are
// drained through the output channel, both sides idling at random. A
// scoreboard class keeps its own copy of the registers and step sizes,
// computes the escape count of every accepted pixel in fixed point and checks
// each returned transaction in order. A directed part covers reset settings,
// a zero limit, the largest limit, extreme and reversed bounds and clamped
// image sides; random phases then reprogram all registers between bursts.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top_test;
    import met_pkg::*;

    localparam int     CYCLE_LIMIT      = 4_000_000;
    localparam int     RANDOM_PHASES    = 15;
    localparam int     PIXELS_PER_PHASE = 100;
    localparam int     DRAIN_CYCLES     = 64;
    localparam int     ONE_Q            = 1 << FRAC_BITS;
    localparam longint FIX_HI           = 64'sh7FFF_FFFF;
    localparam longint FIX_LO           = -64'sh8000_0000;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_pixel_count;

    class escape_count_scoreboard;
        logic [SIDE_W-1:0]  width_reg;
        logic [SIDE_W-1:0]  height_reg;
        logic [COUNT_W-1:0] limit_reg;
        int                 x_lo;
        int                 x_hi;
        int                 y_lo;
        int                 y_hi;
        longint             step_re;
        longint             step_im;
        t_pixel_count       pending_counts[$];
        int                 failures;

        function new();
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            limit_reg  = RST_ITERATION_LIMIT;
            x_lo       = RST_X_MIN;
            x_hi       = RST_X_MAX;
            y_lo       = RST_Y_MIN;
            y_hi       = RST_Y_MAX;
            failures   = 0;
            refresh_steps();
        endfunction

        function longint step_of(int lo, int hi, logic [SIDE_W-1:0] side);
            longint d;
            d = side;
            if (d < 1) d = 1;
            if (d > MAX_SIDE) d = MAX_SIDE;
            return (longint'(hi) - longint'(lo)) / d;
        endfunction

        function void refresh_steps();
            step_re = step_of(x_lo, x_hi, width_reg);
            step_im = step_of(y_lo, y_hi, height_reg);
        endfunction

        function int clamp32(longint v);
            if (v > FIX_HI) return int'(FIX_HI);
            if (v < FIX_LO) return int'(FIX_LO);
            return int'(v);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:     width_reg = data[SIDE_W-1:0];
                CFG_IMAGE_HEIGHT:    height_reg = data[SIDE_W-1:0];
                CFG_ITERATION_LIMIT: limit_reg = data[COUNT_W-1:0];
                CFG_X_MIN:           x_lo = data;
                CFG_X_MAX:           x_hi = data;
                CFG_Y_MIN:           y_lo = data;
                CFG_Y_MAX:           y_hi = data;
                default:             return;
            endcase
            refresh_steps();
        endfunction

        function logic [COUNT_W-1:0] escape_count_of(logic [COORD_W-1:0] col,
                                                     logic [COORD_W-1:0] row);
            longint            col_l;
            longint            row_l;
            int                c_re;
            int                c_im;
            int                z_re;
            int                z_im;
            longint            sq_re;
            longint            sq_im;
            longint            sq_ri;
            longint unsigned   mag;
            int unsigned       n;
            col_l = col;
            row_l = row;
            c_re  = clamp32(longint'(x_lo) + col_l * step_re);
            c_im  = clamp32(longint'(y_lo) + row_l * step_im);
            z_re  = 0;
            z_im  = 0;
            n     = 0;
            while (n < limit_reg) begin
                sq_re = longint'(z_re) * longint'(z_re);
                sq_im = longint'(z_im) * longint'(z_im);
                sq_ri = longint'(z_re) * longint'(z_im);
                mag   = sq_re + sq_im;
                if ((mag >> FRAC_BITS) >= (64'd4 << FRAC_BITS)) break;
                z_re = clamp32(((sq_re - sq_im) >>> FRAC_BITS) + longint'(c_re));
                z_im = clamp32((sq_ri >>> (FRAC_BITS - 1)) + longint'(c_im));
                n++;
            end
            return COUNT_W'(n);
        endfunction

        function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
            t_pixel_count want;
            want.count  = escape_count_of(col, row);
            want.column = col;
            want.row    = row;
            pending_counts.push_back(want);
        endfunction

        function void check_count(logic [COUNT_W-1:0] count, logic [COORD_W-1:0] col,
                                  logic [COORD_W-1:0] row);
            t_pixel_count want;
            if (pending_counts.size() == 0) begin
                $error("result with no pixel outstanding: column %0d row %0d", col, row);
                failures++;
                return;
            end
            want = pending_counts.pop_front();
            if (count !== want.count) begin
                $error("escape_count: expected %0d, actual %0d", want.count, count);
                failures++;
            end
            if (col !== want.column) begin
                $error("out_column: expected %0d, actual %0d", want.column, col);
                failures++;
            end
            if (row !== want.row) begin
                $error("out_row: expected %0d, actual %0d", want.row, row);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [COORD_W-1:0]    i_column = '0;
    logic [COORD_W-1:0]    i_row = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [COUNT_W-1:0]    o_escape_count;
    logic [COORD_W-1:0]    o_out_column;
    logic [COORD_W-1:0]    o_out_row;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    escape_count_scoreboard sb;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_hold = 0;
    int results_seen = 0;
    int cycle_count = 0;

    mandelbrot_escape_time_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_column       (i_column),
        .i_row          (i_row),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_escape_count (o_escape_count),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check each transaction, then hold stall for a random spell
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_count(o_escape_count, o_out_column, o_out_row);
                results_seen++;
                if (results_seen % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
                rx_hold = rx_quiet ? 0 : $urandom_range(0, 6);
                if (rx_hold > 0) i_out_stall <= 1'b1;
            end else if (rx_hold > 0) begin
                rx_hold--;
                if (rx_hold == 0) i_out_stall <= 1'b0;
            end
        end
    end

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    task automatic program_window(logic [31:0] w, logic [31:0] h, logic [31:0] lim,
                                  logic [31:0] xl, logic [31:0] xh,
                                  logic [31:0] yl, logic [31:0] yh);
        set_register(CFG_IMAGE_WIDTH, w);
        set_register(CFG_IMAGE_HEIGHT, h);
        set_register(CFG_ITERATION_LIMIT, lim);
        set_register(CFG_X_MIN, xl);
        set_register(CFG_X_MAX, xh);
        set_register(CFG_Y_MIN, yl);
        set_register(CFG_Y_MAX, yh);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_column   <= col;
        i_row      <= row;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(col, row);
    endtask

    task automatic wait_drained();
        while (sb.pending_counts.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] draw_side();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0:       v[SIDE_W-1:0] = '0;
            1:       v[SIDE_W-1:0] = SIDE_W'($urandom_range(MAX_SIDE + 1, 8191));
            2:       v[SIDE_W-1:0] = SIDE_W'(1);
            default: v[SIDE_W-1:0] = SIDE_W'($urandom_range(2, MAX_SIDE));
        endcase
        return v;
    endfunction

    // mostly inside the image, sometimes anywhere in the coordinate range
    function automatic logic [COORD_W-1:0] pick_coord(logic [SIDE_W-1:0] side);
        int span;
        span = (side == 0) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : int'(side);
        if ($urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, 4095));
        return COORD_W'($urandom_range(0, span - 1));
    endfunction

    initial begin
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] lim;
        int          xl;
        int          xh;
        int          yl;
        int          yh;
        int          swap;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, including columns far outside the image
        tx_quiet = 1'b1;
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(639, 479);
        send_pixel(320, 240);
        send_pixel(4095, 0);
        i_in_valid <= 1'b0;
        wait_drained();

        // zero limit, upper data bits set
        program_window(640, 480, 32'hFFFF_0000, RST_X_MIN, RST_X_MAX, RST_Y_MIN, RST_Y_MAX);
        tx_quiet = 1'b0;
        send_pixel(320, 240);
        i_in_valid <= 1'b0;
        wait_drained();

        // largest limit at the origin, zero sides clamped to one
        program_window(0, 0, 32'h0000_FFFF, 0, 0, 0, 0);
        send_pixel(0, 0);
        i_in_valid <= 1'b0;
        wait_drained();

        // full-range bounds: saturation of c and z, oversize width clamped
        program_window(32'hFFFF_FFFF, 32'h0000_E000, 32'h0001_0014,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 1);
        send_pixel(1, 2048);
        i_in_valid <= 1'b0;
        wait_drained();

        // reversed bounds give negative steps
        program_window(MAX_SIDE, MAX_SIDE, 100, ONE_Q / 2, -2 * ONE_Q, ONE_Q, -ONE_Q);
        tx_quiet = 1'b1;
        send_pixel(2048, 2048);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        i_in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            w   = draw_side();
            h   = draw_side();
            lim = $urandom;
            case ($urandom_range(0, 9))
                0:       lim[COUNT_W-1:0] = '0;
                1:       lim[COUNT_W-1:0] = COUNT_W'($urandom_range(128, 300));
                default: lim[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 48));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                xl = $urandom;
                xh = $urandom;
                yl = $urandom;
                yh = $urandom;
            end else begin
                xl = -5 * (ONE_Q / 2) + int'($urandom_range(0, 3 * ONE_Q));
                xh = xl + int'($urandom_range(1, 3 * ONE_Q));
                yl = -3 * (ONE_Q / 2) + int'($urandom_range(0, 2 * ONE_Q));
                yh = yl + int'($urandom_range(1, 2 * ONE_Q));
                if ($urandom_range(0, 4) == 0) begin
                    swap = xl;
                    xl   = xh;
                    xh   = swap;
                end
            end
            program_window(w, h, lim, xl, xh, yl, yh);
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
                send_pixel(pick_coord(w[SIDE_W-1:0]), pick_coord(h[SIDE_W-1:0]));
            end
            i_in_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending_counts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/met_pkg.sv
hw/rtl/met_step_div.sv
hw/rtl/met_front.sv
hw/rtl/met_fifo.sv
hw/rtl/met_iter.sv
hw/rtl/mandelbrot_escape_time_top.sv
tb/mandelbrot_escape_time_top_test.sv
